FILE: rtl/ldfs_pkg.sv
package ldfs_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 64;
    localparam int DEFAULT_MAX_HEIGHT = 64;

    localparam int COORD_W = 12;
    localparam int COLOR_W = 32;
    localparam int DIM_W   = 7;
    localparam int DELTA_W = 13;
    localparam int ERR_W   = 14;

    localparam logic [DIM_W-1:0]   DIM_RESET  = 7'd64;
    localparam logic [COLOR_W-1:0] BLANK_PIXEL = 32'h0000_0000;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_LINE  = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_LINE,
        OP_NONE
    } ldfs_op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WALK
    } ldfs_state_t;

    typedef struct packed {
        ldfs_op_t                   op;
        logic signed [COORD_W-1:0]  x0;
        logic signed [COORD_W-1:0]  y0;
        logic signed [COORD_W-1:0]  x1;
        logic signed [COORD_W-1:0]  y1;
        logic [COLOR_W-1:0]         color;
        logic [DELTA_W-1:0]         dx;
        logic [DELTA_W-1:0]         dy;
        logic                       step_x_neg;
        logic                       step_y_neg;
        logic signed [ERR_W-1:0]    err0;
    } ldfs_cmd_t;

    typedef struct packed {
        logic clearing;
    } ldfs_status_t;

    // point inside the active area
    function automatic logic in_area(
        logic signed [COORD_W-1:0] x,
        logic signed [COORD_W-1:0] y,
        logic [DIM_W-1:0]          aw,
        logic [DIM_W-1:0]          ah
    );
        logic ok_x;
        logic ok_y;
        ok_x = !x[COORD_W-1] && (x[COORD_W-2:0] < {4'b0000, aw});
        ok_y = !y[COORD_W-1] && (y[COORD_W-2:0] < {4'b0000, ah});
        return ok_x && ok_y;
    endfunction

endpackage

FILE: rtl/ldfs_req_if.sv
interface ldfs_req_if
    import ldfs_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [1:0]                func;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0]        color;

    modport source (
        output valid, func, start_x, start_y, end_x, end_y, color,
        input  ready
    );

    modport sink (
        input  valid, func, start_x, start_y, end_x, end_y, color,
        output ready
    );
endinterface

FILE: rtl/ldfs_rsp_if.sv
interface ldfs_rsp_if
    import ldfs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_value;

    modport source (
        output valid, pixel_value,
        input  ready
    );

    modport sink (
        input  valid, pixel_value,
        output ready
    );
endinterface

FILE: rtl/ldfs_front.sv
module ldfs_front
    import ldfs_pkg::*;
(
    ldfs_req_if.sink    req,
    input  ldfs_status_t status,
    input  logic        q_full,
    output logic        push,
    output ldfs_cmd_t   push_cmd
);

    logic signed [DELTA_W-1:0] diff_x;
    logic signed [DELTA_W-1:0] diff_y;
    logic [DELTA_W-1:0]        dx;
    logic [DELTA_W-1:0]        dy;

    assign req.ready = !q_full && !status.clearing;
    assign push      = req.valid && req.ready;

    always_comb
    begin
        diff_x = DELTA_W'($signed({req.end_x[COORD_W-1], req.end_x})
                 - $signed({req.start_x[COORD_W-1], req.start_x}));
        diff_y = DELTA_W'($signed({req.end_y[COORD_W-1], req.end_y})
                 - $signed({req.start_y[COORD_W-1], req.start_y}));
        dx = diff_x[DELTA_W-1] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
        dy = diff_y[DELTA_W-1] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);

        push_cmd.x0         = req.start_x;
        push_cmd.y0         = req.start_y;
        push_cmd.x1         = req.end_x;
        push_cmd.y1         = req.end_y;
        push_cmd.color      = req.color;
        push_cmd.dx         = dx;
        push_cmd.dy         = dy;
        push_cmd.step_x_neg = !(req.start_x < req.end_x);
        push_cmd.step_y_neg = !(req.start_y < req.end_y);
        // halving rounds toward zero, both halves are non-negative here
        if (dx > dy)
        begin
            push_cmd.err0 = $signed({2'b00, dx[DELTA_W-1:1]});
        end
        else
        begin
            push_cmd.err0 = ERR_W'(-$signed({2'b00, dy[DELTA_W-1:1]}));
        end

        unique case (req.func)
            FUNC_WRITE: push_cmd.op = OP_WRITE;
            FUNC_READ:  push_cmd.op = OP_READ;
            FUNC_LINE:  push_cmd.op = OP_LINE;
            default:    push_cmd.op = OP_NONE;
        endcase
    end

endmodule

FILE: rtl/ldfs_queue.sv
module ldfs_queue
    import ldfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ldfs_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output ldfs_cmd_t pop_cmd,
    output logic      empty
);

    ldfs_cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   cnt_reg;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   cnt_next;

    assign full    = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/ldfs_back.sv
module ldfs_back
    import ldfs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  ldfs_cmd_t     q_cmd,
    output logic          pop,
    input  logic [DIM_W-1:0] active_w,
    input  logic [DIM_W-1:0] active_h,
    output ldfs_status_t  status,
    ldfs_rsp_if.source    rsp
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [AW-1:0] pix_addr(
        logic signed [COORD_W-1:0] x,
        logic signed [COORD_W-1:0] y
    );
        return AW'(AW'(y[COORD_W-2:0]) * AW'(MAX_WIDTH) + AW'(x[COORD_W-2:0]));
    endfunction

    logic [COLOR_W-1:0] mem [DEPTH];

    ldfs_state_t               state_reg;
    ldfs_state_t               state_next;
    logic [AW-1:0]             clr_cnt_reg;
    logic [AW-1:0]             clr_cnt_next;
    ldfs_cmd_t                 cur_reg;
    ldfs_cmd_t                 cur_next;
    logic signed [COORD_W-1:0] walk_x_reg;
    logic signed [COORD_W-1:0] walk_x_next;
    logic signed [COORD_W-1:0] walk_y_reg;
    logic signed [COORD_W-1:0] walk_y_next;
    logic signed [ERR_W-1:0]   walk_err_reg;
    logic signed [ERR_W-1:0]   walk_err_next;
    logic                      rd_zero_reg;
    logic                      rd_zero_next;
    logic [COLOR_W-1:0]        rd_data_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [COLOR_W-1:0]        out_data_reg;
    logic [COLOR_W-1:0]        out_data_next;

    logic                      we;
    logic [AW-1:0]             waddr;
    logic [COLOR_W-1:0]        wdata;
    logic                      re;
    logic [AW-1:0]             raddr;
    logic                      out_load;
    logic                      slot_free;
    logic                      at_end;
    logic                      go_x;
    logic                      go_y;
    logic signed [ERR_W:0]     e2_w;
    logic signed [ERR_W:0]     dx_w;
    logic signed [ERR_W:0]     dy_w;
    logic signed [ERR_W:0]     err_sum;
    logic                      q_in_area;

    assign slot_free       = !out_valid_reg || rsp.ready;
    assign at_end          = (walk_x_reg == cur_reg.x1) && (walk_y_reg == cur_reg.y1);
    assign status.clearing = (state_reg == ST_CLEAR);
    assign rsp.valid       = out_valid_reg;
    assign rsp.pixel_value = out_data_reg;
    assign q_in_area       = in_area(q_cmd.x0, q_cmd.y0, active_w, active_h);

    // one bresenham step from the current point
    always_comb
    begin
        e2_w    = (ERR_W+1)'(walk_err_reg);
        dx_w    = $signed({2'b00, cur_reg.dx});
        dy_w    = $signed({2'b00, cur_reg.dy});
        go_x    = e2_w > -dx_w;
        go_y    = e2_w < dy_w;
        err_sum = e2_w - (go_x ? dy_w : '0) + (go_y ? dx_w : '0);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_next       = cur_reg;
        walk_x_next    = walk_x_reg;
        walk_y_next    = walk_y_reg;
        walk_err_next  = walk_err_reg;
        rd_zero_next   = rd_zero_reg;
        pop            = 1'b0;
        we             = 1'b0;
        waddr          = '0;
        wdata          = BLANK_PIXEL;
        re             = 1'b0;
        raddr          = '0;
        out_load       = 1'b0;
        out_data_next  = BLANK_PIXEL;

        unique case (state_reg)
            ST_CLEAR:
            begin
                we           = 1'b1;
                waddr        = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_cmd.op)
                        OP_READ:
                        begin
                            pop          = 1'b1;
                            re           = q_in_area;
                            raddr        = pix_addr(q_cmd.x0, q_cmd.y0);
                            rd_zero_next = !q_in_area;
                            state_next   = ST_READ;
                        end
                        OP_LINE:
                        begin
                            pop           = 1'b1;
                            cur_next      = q_cmd;
                            walk_x_next   = q_cmd.x0;
                            walk_y_next   = q_cmd.y0;
                            walk_err_next = q_cmd.err0;
                            state_next    = ST_WALK;
                        end
                        default:
                        begin
                            if (slot_free)
                            begin
                                pop      = 1'b1;
                                out_load = 1'b1;
                                we       = (q_cmd.op == OP_WRITE) && q_in_area;
                                waddr    = pix_addr(q_cmd.x0, q_cmd.y0);
                                wdata    = q_cmd.color;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    out_data_next = rd_zero_reg ? BLANK_PIXEL : rd_data_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (at_end)
                begin
                    if (slot_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    we    = in_area(walk_x_reg, walk_y_reg, active_w, active_h);
                    waddr = pix_addr(walk_x_reg, walk_y_reg);
                    wdata = cur_reg.color;
                    walk_err_next = err_sum[ERR_W-1:0];
                    if (go_x)
                    begin
                        walk_x_next = cur_reg.step_x_neg ? walk_x_reg - 12'sd1
                                                         : walk_x_reg + 12'sd1;
                    end
                    if (go_y)
                    begin
                        walk_y_next = cur_reg.step_y_neg ? walk_y_reg - 12'sd1
                                                         : walk_y_reg + 12'sd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            walk_x_reg    <= '0;
            walk_y_reg    <= '0;
            walk_err_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            walk_x_reg    <= walk_x_next;
            walk_y_reg    <= walk_y_next;
            walk_err_reg  <= walk_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        rd_zero_reg <= rd_zero_next;
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !pop)
        else $error("command taken during clearing pass");

    a_read_goes_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (q_cmd.op == OP_READ)) |=> (state_reg == ST_READ))
        else $error("read transaction did not enter read state");

    a_walk_moves: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WALK) && !at_end)
        |=> ((walk_x_reg != $past(walk_x_reg)) || (walk_y_reg != $past(walk_y_reg))))
        else $error("line walk step did not move");

    a_result_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("pending result overwritten");

endmodule

FILE: rtl/line_draw_frame_store.sv
// Frame store of MAX_WIDTH x MAX_HEIGHT 32-bit pixels with a Bresenham line
// engine; every transaction (write pixel, read pixel, draw line, or the unused
// code) returns exactly one pixel_value, zero for everything but an in-area
// read. After reset the store is swept to zero one word per cycle, during which
// no command is taken; configuration writes are taken at any time. Commands go
// through a two-entry queue to the executing engine, which owns the
// single-write, single-read store: a pixel read goes through the registered
// memory read, and a line is taken from the queue, then plots one point per
// cycle through the store's write port, and then loads its result. Points off
// the active area are skipped; the final endpoint is never plotted.
module line_draw_frame_store
    import ldfs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [DIM_W-1:0]  cfg_data,
    ldfs_req_if.sink          req,
    ldfs_rsp_if.source        rsp
);

    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_height_reg;
    logic [DIM_W-1:0] active_w;
    logic [DIM_W-1:0] active_h;

    ldfs_status_t status;
    logic         q_full;
    logic         q_empty;
    logic         push;
    logic         pop;
    ldfs_cmd_t    push_cmd;
    ldfs_cmd_t    pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_RESET;
            image_height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  image_width_reg  <= cfg_data;
                CFG_HEIGHT: image_height_reg <= cfg_data;
                default:    image_width_reg  <= image_width_reg;
            endcase
        end
    end

    // clamp the active area to the store size
    always_comb
    begin
        if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            active_w = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            active_w = image_width_reg;
        end
        if (32'(image_height_reg) > 32'(MAX_HEIGHT))
        begin
            active_h = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            active_h = image_height_reg;
        end
    end

    ldfs_front u_front (
        .req      (req),
        .status   (status),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ldfs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    ldfs_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_cmd    (pop_cmd),
        .pop      (pop),
        .active_w (active_w),
        .active_h (active_h),
        .status   (status),
        .rsp      (rsp)
    );

endmodule

FILE: tb/tb_line_draw_frame_store.sv
module tb_line_draw_frame_store;
    import ldfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_W      = DEFAULT_MAX_WIDTH;
    localparam int STORE_H      = DEFAULT_MAX_HEIGHT;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 32;
    localparam int PHASE_ITEMS  = 75;
    localparam int REPORT_LIMIT = 10;

    // the package names only the three live operations
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct {
        logic [1:0]                func;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [COLOR_W-1:0]        color;
    } command_t;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_HOLD
    } rx_mode_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [DIM_W-1:0] cfg_data;

    ldfs_req_if req_bus();
    ldfs_rsp_if rsp_bus();

    line_draw_frame_store u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    // shadow copy of the frame and the area registers
    logic [COLOR_W-1:0] shadow_frame [0:STORE_W*STORE_H-1];
    int                 area_w;
    int                 area_h;

    logic [COLOR_W-1:0] pixel_value_q [$];
    logic [COLOR_W-1:0] expected_value;

    int       mismatch_count = 0;
    int       checked_count  = 0;
    int       cycle_count    = 0;
    int       op_count [4];
    int       area_settings  = 0;
    int       burst_left     = 0;
    bit       gaps_on        = 1'b1;
    rx_mode_t rx_mode        = RX_OPEN;
    int       rx_left        = 0;
    int       rx_tick        = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixel values outstanding",
                     cycle_count, pixel_value_q.size());
            $display("line_draw_frame_store: mismatch");
            $finish;
        end
    end

    // receiver: stretches of open, random, periodic and fully held ready
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 30) : $urandom_range(20, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:     rsp_bus.ready = 1'b1;
            RX_RANDOM:   rsp_bus.ready = ($urandom_range(0, 99) < 60);
            RX_PERIODIC: rsp_bus.ready = ((rx_tick % 8) >= 3);
            default:     rsp_bus.ready = 1'b0;
        endcase
    end

    task automatic note_mismatch(string what, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
        if (mismatch_count < REPORT_LIMIT)
            $display("cycle %0d: %s, expected %08h got %08h", cycle_count, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pixel_value_q.size() == 0)
            begin
                note_mismatch("pixel_value with no transaction pending", BLANK_PIXEL,
                              rsp_bus.pixel_value);
            end
            else
            begin
                expected_value = pixel_value_q.pop_front();
                checked_count++;
                if (rsp_bus.pixel_value !== expected_value)
                    note_mismatch("pixel_value differs", expected_value, rsp_bus.pixel_value);
            end
        end
    end

    function automatic bit pixel_visible(int x, int y);
        int aw;
        int ah;
        aw = (area_w > STORE_W) ? STORE_W : area_w;
        ah = (area_h > STORE_H) ? STORE_H : area_h;
        return (x >= 0) && (y >= 0) && (x < aw) && (y < ah);
    endfunction

    function automatic void plot_pixel(int x, int y, logic [COLOR_W-1:0] color);
        if (pixel_visible(x, y))
            shadow_frame[y*STORE_W + x] = color;
    endfunction

    // applies one command to the shadow frame and returns its pixel_value
    function automatic logic [COLOR_W-1:0] execute_command(command_t c);
        int                 x;
        int                 y;
        int                 x_end;
        int                 y_end;
        int                 dx;
        int                 dy;
        int                 step_x;
        int                 step_y;
        int                 err;
        int                 err_prev;
        logic [COLOR_W-1:0] value;
        value = BLANK_PIXEL;
        x     = c.x0;
        y     = c.y0;
        x_end = c.x1;
        y_end = c.y1;
        case (c.func)
            FUNC_WRITE:
                plot_pixel(x, y, c.color);
            FUNC_READ:
                if (pixel_visible(x, y))
                    value = shadow_frame[y*STORE_W + x];
            FUNC_LINE:
            begin
                dx     = (x_end > x) ? x_end - x : x - x_end;
                dy     = (y_end > y) ? y_end - y : y - y_end;
                step_x = (x < x_end) ? 1 : -1;
                step_y = (y < y_end) ? 1 : -1;
                err    = (dx > dy) ? dx / 2 : -(dy / 2);
                // the final endpoint is never plotted
                while (!(x == x_end && y == y_end))
                begin
                    plot_pixel(x, y, c.color);
                    err_prev = err;
                    if (err_prev > -dx)
                    begin
                        err -= dy;
                        x   += step_x;
                    end
                    if (err_prev < dy)
                    begin
                        err += dx;
                        y   += step_y;
                    end
                end
            end
            default: ;
        endcase
        return value;
    endfunction

    function automatic command_t make_command(logic [1:0] func, int x0, int y0, int x1, int y1,
                                              logic [COLOR_W-1:0] color);
        command_t c;
        c.func  = func;
        c.x0    = COORD_W'(x0);
        c.y0    = COORD_W'(y0);
        c.x1    = COORD_W'(x1);
        c.y1    = COORD_W'(y1);
        c.color = color;
        return c;
    endfunction

    task automatic send_command(command_t c);
        int gap;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 16);
                repeat (gap)
                begin
                    @(negedge clk);
                    req_bus.valid = 1'b0;
                end
            end
            burst_left--;
        end
        @(negedge clk);
        req_bus.func    = c.func;
        req_bus.start_x = c.x0;
        req_bus.start_y = c.y0;
        req_bus.end_x   = c.x1;
        req_bus.end_y   = c.y1;
        req_bus.color   = c.color;
        req_bus.valid   = 1'b1;
        do
            @(posedge clk);
        while (!req_bus.ready);
        pixel_value_q.push_back(execute_command(c));
        op_count[c.func]++;
    endtask

    // valid drops first so nothing is taken twice while waiting
    task automatic wait_drained();
        @(negedge clk);
        req_bus.valid = 1'b0;
        while (pixel_value_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic index, int value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = DIM_W'(value);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_area(int width, int height);
        wait_drained();
        repeat (4) @(posedge clk);
        write_register(CFG_WIDTH, width);
        write_register(CFG_HEIGHT, height);
        area_w = width & 'h7F;
        area_h = height & 'h7F;
        area_settings++;
    endtask

    function automatic int pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 15);
        else if (r < 88)
            return int'($urandom_range(0, 72)) - 3;
        else
            return $urandom_range(0, 4095);
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return $urandom;
    endfunction

    task automatic test_pixel_access();
        set_area(64, 64);
        send_command(make_command(FUNC_WRITE, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_command(make_command(FUNC_WRITE, 63, 0, 5, 5, 32'h0000_0000));
        send_command(make_command(FUNC_WRITE, 0, 63, -1, -1, 32'hA5A5_A5A5));
        send_command(make_command(FUNC_WRITE, 63, 63, 2047, -2048, 32'h5A5A_5A5A));
        // off-area writes must not alias onto other words
        send_command(make_command(FUNC_WRITE, 64, 0, 0, 0, 32'h1111_1111));
        send_command(make_command(FUNC_WRITE, -1, 5, 0, 0, 32'h2222_2222));
        send_command(make_command(FUNC_WRITE, 2047, -2048, 0, 0, 32'h3333_3333));
        send_command(make_command(FUNC_READ, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_command(make_command(FUNC_READ, 63, 63, 0, 0, '0));
        send_command(make_command(FUNC_READ, 0, 63, 0, 0, '0));
        send_command(make_command(FUNC_READ, 63, 0, 0, 0, '0));
        send_command(make_command(FUNC_READ, 0, 1, 0, 0, '0));
        send_command(make_command(FUNC_READ, -2048, 2047, 0, 0, '0));
    endtask

    task automatic test_unused_operation();
        send_command(make_command(FUNC_NONE, 0, 0, 10, 10, 32'h0BAD_F00D));
        send_command(make_command(FUNC_READ, 0, 0, 0, 0, '0));
    endtask

    task automatic test_line_walks();
        send_command(make_command(FUNC_LINE, 10, 10, 10, 10, 32'hDEAD_BEEF));
        send_command(make_command(FUNC_READ, 10, 10, 0, 0, '0));
        send_command(make_command(FUNC_LINE, 2, 3, 20, 9, 32'h0102_0304));
        send_command(make_command(FUNC_READ, 20, 9, 0, 0, '0));
        send_command(make_command(FUNC_LINE, 30, 40, 25, 5, 32'hCAFE_0001));
        send_command(make_command(FUNC_LINE, 60, 60, 40, 62, 32'hCAFE_0002));
        send_command(make_command(FUNC_LINE, 5, 50, 12, 60, 32'hCAFE_0003));
        // runs partly off the area on both sides
        send_command(make_command(FUNC_LINE, -5, -3, 70, 50, 32'hCAFE_0004));
        send_command(make_command(FUNC_LINE, -2048, -2048, 2047, 2047, 32'h7777_7777));
        send_command(make_command(FUNC_READ, 30, 30, 0, 0, '0));
        send_command(make_command(FUNC_READ, 2, 3, 0, 0, '0));
    endtask

    task automatic test_random_areas();
        int                        widths  [0:7];
        int                        heights [0:7];
        int                        r;
        int                        pause_at;
        logic [1:0]                func;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        widths  = '{64, 1, 0, 127, 33, 64, 100, 64};
        heights = '{64, 1, 40, 127, 64, 0, 17, 64};
        widths[7]  = $urandom_range(0, 127);
        heights[7] = $urandom_range(0, 127);
        for (int phase = 0; phase < 8; phase++)
        begin
            set_area(widths[phase], heights[phase]);
            gaps_on  = (phase % 2 == 0);
            pause_at = $urandom_range(10, PHASE_ITEMS - 10);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == pause_at)
                    wait_drained();
                r = $urandom_range(0, 99);
                if (r < 35)
                    func = FUNC_WRITE;
                else if (r < 70)
                    func = FUNC_READ;
                else if (r < 95)
                    func = FUNC_LINE;
                else
                    func = FUNC_NONE;
                x0 = COORD_W'(pick_coord());
                y0 = COORD_W'(pick_coord());
                if (func == FUNC_LINE && $urandom_range(0, 99) < 3)
                begin
                    x1 = COORD_W'($urandom);
                    y1 = COORD_W'($urandom);
                end
                else
                begin
                    x1 = COORD_W'(int'(x0) + int'($urandom_range(0, 24)) - 12);
                    y1 = COORD_W'(int'(y0) + int'($urandom_range(0, 24)) - 12);
                end
                send_command(make_command(func, x0, y0, x1, y1, pick_color()));
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_WIDTH;
        cfg_data        = '0;
        req_bus.valid   = 1'b0;
        req_bus.func    = FUNC_WRITE;
        req_bus.start_x = '0;
        req_bus.start_y = '0;
        req_bus.end_x   = '0;
        req_bus.end_y   = '0;
        req_bus.color   = '0;
        rsp_bus.ready   = 1'b0;
        area_w          = DIM_RESET;
        area_h          = DIM_RESET;
        for (int i = 0; i < STORE_W*STORE_H; i++)
            shadow_frame[i] = BLANK_PIXEL;
        for (int i = 0; i < 4; i++)
            op_count[i] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_pixel_access();
        test_unused_operation();
        test_line_walks();
        test_random_areas();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("ran %0d writes, %0d reads, %0d lines, %0d unused codes over %0d area settings",
                 op_count[FUNC_WRITE], op_count[FUNC_READ], op_count[FUNC_LINE],
                 op_count[FUNC_NONE], area_settings);
        $display("compared %0d pixel values in %0d cycles, %0d wrong",
                 checked_count, cycle_count, mismatch_count);
        if (mismatch_count == 0)
            $display("line_draw_frame_store: match");
        else
            $display("line_draw_frame_store: mismatch");
        $finish;
    end

endmodule
